@@ src/permutation_combination_count_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef PERMUTATION_COMBINATION_COUNT_TOP_MACROS_SVH
`define PERMUTATION_COMBINATION_COUNT_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pcc_pkg.sv @@
package pcc_pkg;

    // Widths of the operands and of the result.
    localparam int SET_SIZE_BITS = 8;
    localparam int COUNT_BITS    = 64;
    localparam int WIDE_BITS     = COUNT_BITS + SET_SIZE_BITS;
    localparam int DIV_STEPS     = COUNT_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);
    localparam int STEP_BITS     = 4;

    localparam logic [SET_SIZE_BITS-1:0] SIZE_ONE  = SET_SIZE_BITS'(1);
    localparam logic [SET_SIZE_BITS-1:0] SIZE_ZERO = '0;
    localparam logic [COUNT_BITS-1:0]    COUNT_ONE = COUNT_BITS'(1);
    localparam logic [DIV_CNT_BITS-1:0]  DIV_START = DIV_CNT_BITS'(DIV_STEPS);

    // Operation codes carried by the input beat.
    localparam logic OP_PERM = 1'b0;
    localparam logic OP_COMB = 1'b1;

    // Status codes carried by the result beat.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    typedef struct packed {
        logic [SET_SIZE_BITS-1:0] set_size;
        logic [SET_SIZE_BITS-1:0] pick_count;
        logic                     op;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [1:0]            status;
    } out_beat_t;

    // Datapath operations selected by one control word.
    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_MUL,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_EMIT_OK,
        UOP_EMIT_ERR,
        UOP_EMIT_OVF
    } uop_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        COND_IN_VALID,
        COND_K_GT_N,
        COND_LOOP_DONE,
        COND_OVF,
        COND_NOT_COMB,
        COND_DIV_DONE,
        COND_OUT_FREE
    } cond_t;

    // What happens when the condition is false.
    typedef enum logic {
        SEQ_NEXT,
        SEQ_HOLD
    } seq_mode_t;

    typedef logic [STEP_BITS-1:0] step_t;

    // Program addresses.
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_RANGE    = 4'd1;
    localparam step_t STEP_LOOP     = 4'd2;
    localparam step_t STEP_OVCHK    = 4'd3;
    localparam step_t STEP_MODE     = 4'd4;
    localparam step_t STEP_DIV      = 4'd5;
    localparam step_t STEP_EMIT_OK  = 4'd6;
    localparam step_t STEP_EMIT_ERR = 4'd7;
    localparam step_t STEP_EMIT_OVF = 4'd8;

    typedef struct packed {
        uop_t      uop;
        cond_t     cond;
        seq_mode_t mode;
        step_t     target;
    } ctrl_word_t;

    // Condition flags reported by the datapath.
    typedef struct packed {
        logic in_valid;
        logic k_gt_n;
        logic loop_done;
        logic ovf;
        logic comb;
        logic div_done;
        logic out_free;
    } dp_flags_t;

    // Control program: jump to target when the condition holds, else advance or hold.
    function automatic ctrl_word_t microcode(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE:     w = '{UOP_LOAD,     COND_IN_VALID,  SEQ_HOLD, STEP_RANGE};
            STEP_RANGE:    w = '{UOP_NOP,      COND_K_GT_N,    SEQ_NEXT, STEP_EMIT_ERR};
            STEP_LOOP:     w = '{UOP_MUL,      COND_LOOP_DONE, SEQ_HOLD, STEP_OVCHK};
            STEP_OVCHK:    w = '{UOP_NOP,      COND_OVF,       SEQ_NEXT, STEP_EMIT_OVF};
            STEP_MODE:     w = '{UOP_DIV_INIT, COND_NOT_COMB,  SEQ_NEXT, STEP_EMIT_OK};
            STEP_DIV:      w = '{UOP_DIV_STEP, COND_DIV_DONE,  SEQ_HOLD, STEP_EMIT_OK};
            STEP_EMIT_OK:  w = '{UOP_EMIT_OK,  COND_OUT_FREE,  SEQ_HOLD, STEP_IDLE};
            STEP_EMIT_ERR: w = '{UOP_EMIT_ERR, COND_OUT_FREE,  SEQ_HOLD, STEP_IDLE};
            STEP_EMIT_OVF: w = '{UOP_EMIT_OVF, COND_OUT_FREE,  SEQ_HOLD, STEP_IDLE};
            default:       w = '{UOP_NOP,      COND_IN_VALID,  SEQ_NEXT, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/pcc_sequencer.sv @@
module pcc_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  pcc_pkg::dp_flags_t  flags,
    output pcc_pkg::ctrl_word_t ctrl
);
    import pcc_pkg::*;

    step_t      pc_reg;
    step_t      pc_next;
    ctrl_word_t word;
    logic       cond_true;

    // Fetch the control word of the current step.
    assign word = microcode(pc_reg);
    assign ctrl = word;

    // Evaluate the selected jump condition.
    always_comb
    begin
        case (word.cond)
            COND_IN_VALID:  cond_true = flags.in_valid;
            COND_K_GT_N:    cond_true = flags.k_gt_n;
            COND_LOOP_DONE: cond_true = flags.loop_done;
            COND_OVF:       cond_true = flags.ovf;
            COND_NOT_COMB:  cond_true = !flags.comb;
            COND_DIV_DONE:  cond_true = flags.div_done;
            COND_OUT_FREE:  cond_true = flags.out_free;
            default:        cond_true = 1'b0;
        endcase
    end

    // Jump, hold or advance.
    always_comb
    begin
        if (cond_true)
        begin
            pc_next = word.target;
        end
        else if (word.mode == SEQ_HOLD)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/pcc_datapath.sv @@
module pcc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pcc_pkg::ctrl_word_t ctrl,
    output pcc_pkg::dp_flags_t  flags,
    input  logic                src_valid,
    output logic                src_stall,
    input  pcc_pkg::in_beat_t   src_data,
    output logic                dst_valid,
    input  logic                dst_stall,
    output pcc_pkg::out_beat_t  dst_data
);
    import pcc_pkg::*;

    logic [SET_SIZE_BITS-1:0] set_size_reg, set_size_next;
    logic [SET_SIZE_BITS-1:0] pick_count_reg, pick_count_next;
    logic                     comb_reg, comb_next;
    logic [COUNT_BITS-1:0]    running_product_reg, running_product_next;
    logic [COUNT_BITS-1:0]    divisor_value_reg, divisor_value_next;
    logic [COUNT_BITS-1:0]    divide_remainder_reg, divide_remainder_next;
    logic [SET_SIZE_BITS-1:0] loop_factor_reg, loop_factor_next;
    logic [SET_SIZE_BITS-1:0] fact_index_reg, fact_index_next;
    logic [SET_SIZE_BITS-1:0] left_reg, left_next;
    logic                     ovf_reg, ovf_next;
    logic [DIV_CNT_BITS-1:0]  div_count_reg, div_count_next;
    logic                     out_valid_reg, out_valid_next;
    out_beat_t                out_reg, out_next;

    logic [WIDE_BITS-1:0]     prod_wide;
    logic [WIDE_BITS-1:0]     fact_wide;
    logic                     prod_ovf;
    logic [COUNT_BITS:0]      div_shift;
    logic [COUNT_BITS:0]      div_diff;
    logic                     div_ge;
    logic                     loop_done;
    logic                     div_done;
    logic                     out_free;
    logic [SET_SIZE_BITS-1:0] first_factor;

    // One factor of the falling product and one of k! per cycle.
    assign prod_wide = WIDE_BITS'(running_product_reg) * WIDE_BITS'(loop_factor_reg);
    assign fact_wide = WIDE_BITS'(divisor_value_reg) * WIDE_BITS'(fact_index_reg);
    assign prod_ovf  = |prod_wide[WIDE_BITS-1:COUNT_BITS];

    // One restoring division step: quotient bits shift into the product register.
    assign div_shift = {divide_remainder_reg, running_product_reg[COUNT_BITS-1]};
    assign div_diff  = div_shift - {1'b0, divisor_value_reg};
    assign div_ge    = div_shift >= {1'b0, divisor_value_reg};

    assign loop_done    = (left_reg == SIZE_ZERO) || ovf_reg;
    assign div_done     = (div_count_reg == '0);
    assign out_free     = !out_valid_reg || !dst_stall;
    assign first_factor = src_data.set_size - src_data.pick_count + SIZE_ONE;

    assign flags.in_valid  = src_valid;
    assign flags.k_gt_n    = pick_count_reg > set_size_reg;
    assign flags.loop_done = loop_done;
    assign flags.ovf       = ovf_reg;
    assign flags.comb      = comb_reg;
    assign flags.div_done  = div_done;
    assign flags.out_free  = out_free;

    // Inputs are taken only in the idle step.
    assign src_stall = (ctrl.uop != UOP_LOAD);
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

    // Datapath operations; all but the divider setup are gated by the condition that ends their step.
    always_comb
    begin
        set_size_next         = set_size_reg;
        pick_count_next       = pick_count_reg;
        comb_next             = comb_reg;
        running_product_next  = running_product_reg;
        divisor_value_next    = divisor_value_reg;
        divide_remainder_next = divide_remainder_reg;
        loop_factor_next      = loop_factor_reg;
        fact_index_next       = fact_index_reg;
        left_next             = left_reg;
        ovf_next              = ovf_reg;
        div_count_next        = div_count_reg;
        out_next              = out_reg;
        out_valid_next        = out_valid_reg && dst_stall;
        case (ctrl.uop)
            UOP_LOAD:
            begin
                if (src_valid)
                begin
                    set_size_next        = src_data.set_size;
                    pick_count_next      = src_data.pick_count;
                    comb_next            = (src_data.op == OP_COMB);
                    running_product_next = COUNT_ONE;
                    divisor_value_next   = COUNT_ONE;
                    loop_factor_next     = first_factor;
                    fact_index_next      = SIZE_ONE;
                    left_next            = src_data.pick_count;
                    ovf_next             = 1'b0;
                end
            end
            UOP_MUL:
            begin
                if (!loop_done)
                begin
                    running_product_next = prod_wide[COUNT_BITS-1:0];
                    divisor_value_next   = fact_wide[COUNT_BITS-1:0];
                    ovf_next             = prod_ovf;
                    loop_factor_next     = loop_factor_reg + SIZE_ONE;
                    fact_index_next      = fact_index_reg + SIZE_ONE;
                    left_next            = left_reg - SIZE_ONE;
                end
            end
            UOP_DIV_INIT:
            begin
                divide_remainder_next = '0;
                div_count_next        = DIV_START;
            end
            UOP_DIV_STEP:
            begin
                if (!div_done)
                begin
                    divide_remainder_next = div_ge ? div_diff[COUNT_BITS-1:0]
                                                   : div_shift[COUNT_BITS-1:0];
                    running_product_next  = {running_product_reg[COUNT_BITS-2:0], div_ge};
                    div_count_next        = div_count_reg - DIV_CNT_BITS'(1);
                end
            end
            UOP_EMIT_OK:
            begin
                if (out_free)
                begin
                    out_next.count  = running_product_reg;
                    out_next.status = STATUS_OK;
                    out_valid_next  = 1'b1;
                end
            end
            UOP_EMIT_ERR:
            begin
                if (out_free)
                begin
                    out_next.count  = '0;
                    out_next.status = STATUS_RANGE;
                    out_valid_next  = 1'b1;
                end
            end
            UOP_EMIT_OVF:
            begin
                if (out_free)
                begin
                    out_next.count  = '1;
                    out_next.status = STATUS_OVERFLOW;
                    out_valid_next  = 1'b1;
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    // Payload and working registers; the product and divisor start at one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg         <= SIZE_ZERO;
            pick_count_reg       <= SIZE_ZERO;
            comb_reg             <= 1'b0;
            running_product_reg  <= COUNT_ONE;
            divisor_value_reg    <= COUNT_ONE;
            divide_remainder_reg <= '0;
            loop_factor_reg      <= SIZE_ZERO;
            fact_index_reg       <= SIZE_ZERO;
            left_reg             <= SIZE_ZERO;
            ovf_reg              <= 1'b0;
            div_count_reg        <= '0;
            out_reg              <= '0;
        end
        else
        begin
            set_size_reg         <= set_size_next;
            pick_count_reg       <= pick_count_next;
            comb_reg             <= comb_next;
            running_product_reg  <= running_product_next;
            divisor_value_reg    <= divisor_value_next;
            divide_remainder_reg <= divide_remainder_next;
            loop_factor_reg      <= loop_factor_next;
            fact_index_reg       <= fact_index_next;
            left_reg             <= left_next;
            ovf_reg              <= ovf_next;
            div_count_reg        <= div_count_next;
            out_reg              <= out_next;
        end
    end

    // Output beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/permutation_combination_count_top.sv @@
// An input beat is taken only in the idle step. A pick with k > n goes straight to a
// range result; else the loop multiplies the k factors, stopping early on overflow, and
// nCk then divides the product by k!. No new beat is taken before the result is in the
// output register. A fitting product has k <= 20; overflow ends the loop by the 21st factor.
// A new input beat is taken while a finished result still waits in the output register.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops the result valid.
module permutation_combination_count_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  pcc_pkg::in_beat_t  src_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output pcc_pkg::out_beat_t dst_data
);
    import pcc_pkg::*;

    ctrl_word_t ctrl;
    dp_flags_t  flags;

    // Microprogram sequencer.
    pcc_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Multiply, divide and output datapath.
    pcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule

@@ src/pcc_checker.sv @@
`include "permutation_combination_count_top_macros.svh"

module pcc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               src_valid,
    input logic               src_stall,
    input logic               dst_valid,
    input logic               dst_stall,
    input pcc_pkg::out_beat_t dst_data
);
    import pcc_pkg::*;

    logic range_beat;
    logic ovf_beat;

    // Result beats that carry an error status.
    assign range_beat = dst_valid && (dst_data.status == STATUS_RANGE);
    assign ovf_beat   = dst_valid && (dst_data.status == STATUS_OVERFLOW);

    // A result beat never carries the unused status code.
    `PCC_ASSERT_NOW(a_status_code, dst_valid, dst_data.status <= STATUS_RANGE, "bad status code")

    // A pick larger than the set gives a zero count.
    `PCC_ASSERT_NOW(a_range_zero, range_beat, dst_data.count == '0, "range count not zero")

    // An overflow gives an all-ones count.
    `PCC_ASSERT_NOW(a_ovf_ones, ovf_beat, dst_data.count == '1, "overflow count not all ones")

    // In the cycle after an input beat is taken, the input is stalled.
    `PCC_ASSERT_NEXT(a_busy_after_accept, src_valid && !src_stall, src_stall, "input taken twice")

    // A stalled result beat holds.
    `PCC_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_data), "held")

endmodule

bind permutation_combination_count_top pcc_checker u_pcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);

@@ test/permutation_combination_count_top_test.sv @@
module permutation_combination_count_top_test;

    import pcc_pkg::*;

    // Run limits, in clock cycles or in items.
    localparam int QUIET_LIMIT   = 5000;
    localparam int LONG_HOLD     = 600;
    localparam int DRAIN_CYCLES  = 400;
    localparam int PHASE_ITEMS   = 180;
    localparam int PRESSURE_ITEMS = 30;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    in_beat_t  src_data;
    logic      dst_valid;
    logic      dst_stall;
    out_beat_t dst_data;

    // Idle and stall rates in percent, and the long receiver hold-off request.
    int unsigned src_idle_pct;
    int unsigned dst_stall_pct;
    bit          pressure_on;
    int unsigned quiet_cycles;

    // Holds the expected count for every accepted input beat, oldest first.
    class count_scoreboard;
        typedef struct {
            in_beat_t  item;
            out_beat_t want;
        } pending_count_t;

        pending_count_t waiting[$];
        int unsigned    mismatches;

        // Falling product n*(n-1)*...*(n-k+1), divided by k! for combinations.
        function out_beat_t falling_count(in_beat_t b);
            out_beat_t    r;
            logic [127:0] wide;
            logic [63:0]  prod;
            logic [63:0]  fact;
            int unsigned  n;
            int unsigned  k;
            int unsigned  f;
            n = b.set_size;
            k = b.pick_count;
            r.count = '0;
            r.status = STATUS_RANGE;
            if (k > n)
                return r;
            prod = COUNT_ONE;
            for (f = n - k + 1; f <= n; f++)
            begin
                wide = {64'd0, prod} * 128'(f);
                if (wide[127:64] != '0)
                begin
                    r.count = '1;
                    r.status = STATUS_OVERFLOW;
                    return r;
                end
                prod = wide[63:0];
            end
            // The product fits, so k! fits as well and divides it exactly.
            if (b.op == OP_COMB)
            begin
                fact = COUNT_ONE;
                for (f = 2; f <= k; f++)
                    fact = fact * 64'(f);
                prod = prod / fact;
            end
            r.count = prod;
            r.status = STATUS_OK;
            return r;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void note_input(in_beat_t b);
            pending_count_t p;
            p.item = b;
            p.want = falling_count(b);
            waiting = {waiting, p};
        endfunction

        function void check_result(out_beat_t got);
            pending_count_t p;
            if (waiting.size() == 0)
            begin
                flag($sformatf("unexpected result beat: count %h status %0d",
                               got.count, got.status));
                return;
            end
            p = waiting.pop_front();
            if (got.count !== p.want.count || got.status !== p.want.status)
                flag($sformatf({"mismatch n=%0d k=%0d op=%0d: expected count %h status %0d,",
                                " got count %h status %0d"},
                               p.item.set_size, p.item.pick_count, p.item.op,
                               p.want.count, p.want.status, got.count, got.status));
        endfunction
    endclass

    count_scoreboard sb = new();

    permutation_combination_count_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Note accepted beats on both channels and watch for a hung block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                sb.note_input(src_data);
            if (dst_valid && !dst_stall)
                sb.check_result(dst_data);
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when pressure is requested.
    initial
    begin : receiver
        int held;
        held = 0;
        dst_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_on)
            begin
                dst_stall <= 1'b1;
                held++;
                if (held >= LONG_HOLD)
                begin
                    held = 0;
                    pressure_on = 1'b0;
                end
            end
            else
                dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);
        end
    end

    function automatic in_beat_t make_beat(int unsigned n, int unsigned k, logic op);
        in_beat_t b;
        b.set_size = SET_SIZE_BITS'(n);
        b.pick_count = SET_SIZE_BITS'(k);
        b.op = op;
        return b;
    endfunction

    // Mostly picks that fit the set, with small k so that many products do not
    // overflow, plus picks near the overflow edge, out-of-range picks and noise.
    function automatic in_beat_t random_beat();
        int unsigned sel;
        int unsigned n;
        int unsigned k;
        sel = $urandom_range(0, 99);
        n = $urandom_range(0, 255);
        if (sel < 15)
            k = (n < 255) ? $urandom_range(n + 1, 255) : $urandom_range(0, 255);
        else if (sel < 60)
            k = $urandom_range(0, (n < 12) ? n : 12);
        else if (sel < 85)
            k = $urandom_range(0, (n < 30) ? n : 30);
        else
            k = $urandom_range(0, 255);
        return make_beat(n, k, $urandom_range(0, 1) ? OP_COMB : OP_PERM);
    endfunction

    // Offer one input beat after a random idle gap and hold it until taken.
    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data <= b;
        do
            @(posedge clk);
        while (src_stall);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned items);
        src_idle_pct = idle_pct;
        dst_stall_pct = stall_pct;
        repeat (items)
            send_beat(random_beat());
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        src_valid <= 1'b0;
        src_data <= '0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        pressure_on = 1'b0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty picks, out-of-range picks, overflow edges and exact quotients.
        send_beat(make_beat(0, 0, OP_PERM));
        send_beat(make_beat(0, 0, OP_COMB));
        send_beat(make_beat(255, 0, OP_PERM));
        send_beat(make_beat(255, 0, OP_COMB));
        send_beat(make_beat(0, 1, OP_PERM));
        send_beat(make_beat(0, 255, OP_COMB));
        send_beat(make_beat(254, 255, OP_PERM));
        send_beat(make_beat(255, 255, OP_PERM));
        send_beat(make_beat(255, 255, OP_COMB));
        send_beat(make_beat(20, 20, OP_PERM));
        send_beat(make_beat(21, 21, OP_PERM));
        send_beat(make_beat(20, 20, OP_COMB));
        send_beat(make_beat(21, 21, OP_COMB));
        send_beat(make_beat(255, 1, OP_PERM));
        send_beat(make_beat(255, 1, OP_COMB));
        send_beat(make_beat(255, 8, OP_PERM));
        send_beat(make_beat(255, 9, OP_PERM));
        send_beat(make_beat(255, 8, OP_COMB));
        send_beat(make_beat(60, 30, OP_COMB));
        send_beat(make_beat(25, 12, OP_COMB));
        send_beat(make_beat(1, 1, OP_COMB));
        send_beat(make_beat(128, 127, OP_PERM));
        send_beat(make_beat(170, 3, OP_COMB));
        send_beat(make_beat(127, 128, OP_COMB));

        // Random beats under each idling pattern.
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(61, 0, PHASE_ITEMS);
        run_phase(0, 61, PHASE_ITEMS);
        run_phase(8, 8, PHASE_ITEMS);

        // Long receiver hold-off while the sender keeps offering beats.
        pressure_on = 1'b1;
        run_phase(0, 0, PRESSURE_ITEMS);

        run_phase($urandom_range(0, 70), $urandom_range(0, 70), PHASE_ITEMS);
        src_valid <= 1'b0;
        dst_stall_pct = 0;

        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.waiting.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
